// ===== rtl/hct_pkg.sv =====
package hct_pkg;

  // field widths fixed by the item format
  localparam int unsigned KEY_W      = 34;
  localparam int unsigned PAY_W      = 64;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 4;

  // default table depth
  localparam int unsigned TABLE_SIZE_DEF = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 2'd3;

  // one stored entry without its chain link
  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } slot_data_t;

  // write enables of the slot store
  typedef struct packed {
    logic we_data;
    logic we_link;
  } mem_wr_t;

endpackage

// ===== rtl/chained_hash_table_linear_probe.sv =====
// channel  | direction | handshake           | payload
// command  | in        | start, busy         | op_i, phone_key_i, name_payload_i
// result   | out       | done_o (one cycle)  | status_o, slot_index_o, found_payload_o
//
// after reset a clearing pass writes every slot with busy high.
// key zero and unknown op answer in the cycle after the transfer.
// other ops: the home slot remainder comes first (fold, reciprocal multiply and
// multiply back on one shared multiplier, then a correction), then each slot visited
// takes a read state and an evaluate state on the single registered memory read
// port, plus one or two writes.
// results cannot be stalled; each sits on the ports for the single done_o cycle.
module chained_hash_table_linear_probe import hct_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       op_i,
  input  logic [KEY_W-1:0]      phone_key_i,
  input  logic [PAY_W-1:0]      name_payload_i,
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic [PAY_W-1:0]      found_payload_o
);

  localparam int unsigned IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_SIZE + 1);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] CntSize = CNT_W'(TABLE_SIZE);
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(TABLE_SIZE - 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_MOD        = 4'd2;
  localparam logic [3:0] S_INS_RD     = 4'd3;
  localparam logic [3:0] S_INS_EV     = 4'd4;
  localparam logic [3:0] S_TAIL_RD    = 4'd5;
  localparam logic [3:0] S_TAIL_EV    = 4'd6;
  localparam logic [3:0] S_LINK_WR    = 4'd7;
  localparam logic [3:0] S_SRCH_RD    = 4'd8;
  localparam logic [3:0] S_SRCH_EV    = 4'd9;
  localparam logic [3:0] S_DEL_RD     = 4'd10;
  localparam logic [3:0] S_DEL_EV     = 4'd11;
  localparam logic [3:0] S_DEL_RELINK = 4'd12;

  logic [3:0]          state_q, state_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [IDX_W-1:0]    cur_q, cur_d;
  logic [IDX_W-1:0]    home_q, home_d;
  logic [IDX_W-1:0]    free_q, free_d;
  logic [IDX_W-1:0]    prev_q, prev_d;
  logic                prev_v_q, prev_v_d;
  logic [IDX_W:0]      link_sv_q, link_sv_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [PAY_W-1:0]    pay_q, pay_d;

  logic                done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]    slot_q, slot_d;
  logic [PAY_W-1:0]    fpay_q, fpay_d;

  logic                mod_start;
  logic                mod_done;
  logic [IDX_W-1:0]    mod_rem;

  mem_wr_t             wr;
  logic [IDX_W-1:0]    waddr;
  slot_data_t          wdata;
  logic [IDX_W:0]      wlink;
  logic [IDX_W-1:0]    raddr;
  slot_data_t          rdata;
  logic [IDX_W:0]      rlink;
  logic [IDX_W-1:0]    cur_next;
  logic [IDX_W+SLOT_OUT_W-1:0] slot_wide;

  hct_mod #(
    .TABLE_SIZE(TABLE_SIZE),
    .IDX_W     (IDX_W)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .key_i  (phone_key_i),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  hct_mem #(
    .TABLE_SIZE(TABLE_SIZE),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .wlink_i(wlink),
    .raddr_i(raddr),
    .rdata_o(rdata),
    .rlink_o(rlink)
  );

  // linear probe step with wrap
  assign cur_next = (cur_q == LastIdx) ? '0 : cur_q + 1'b1;
  assign raddr    = cur_q;
  assign busy     = (state_q != S_IDLE);

  // sequencer
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    cur_d     = cur_q;
    home_d    = home_q;
    free_d    = free_q;
    prev_d    = prev_q;
    prev_v_d  = prev_v_q;
    link_sv_d = link_sv_q;
    op_d      = op_q;
    key_d     = key_q;
    pay_d     = pay_q;
    done_d    = 1'b0;
    status_d  = status_q;
    slot_d    = slot_q;
    fpay_d    = fpay_q;
    mod_start = 1'b0;
    wr        = '0;
    waddr     = cur_q;
    wdata     = '0;
    wlink     = '0;

    unique case (state_q)
      S_CLEAR: begin
        wr.we_data = 1'b1;
        wr.we_link = 1'b1;
        cur_d      = cur_next;
        if (cur_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_d  = op_i;
          key_d = phone_key_i;
          pay_d = name_payload_i;
          if (phone_key_i == '0) begin
            done_d   = 1'b1;
            status_d = ST_ZERO_KEY;
            slot_d   = '0;
            fpay_d   = '0;
          end else begin
            unique case (op_i) inside
              OP_INSERT, OP_SEARCH, OP_DELETE: begin
                mod_start = 1'b1;
                state_d   = S_MOD;
              end
              default: begin
                done_d   = 1'b1;
                status_d = ST_NOT_FOUND;
                slot_d   = '0;
                fpay_d   = '0;
              end
            endcase
          end
        end
      end

      S_MOD: begin
        if (mod_done) begin
          cur_d    = mod_rem;
          home_d   = mod_rem;
          n_d      = '0;
          prev_v_d = 1'b0;
          unique case (op_q)
            OP_INSERT: state_d = S_INS_RD;
            OP_SEARCH: state_d = S_SRCH_RD;
            default:   state_d = S_DEL_RD;
          endcase
        end
      end

      // probe for a free slot starting at home
      S_INS_RD: state_d = S_INS_EV;

      S_INS_EV: begin
        if (!rdata.used) begin
          wr.we_data    = 1'b1;
          wr.we_link    = 1'b1;
          wdata.used    = 1'b1;
          wdata.key     = key_q;
          wdata.payload = pay_q;
          free_d        = cur_q;
          if (cur_q == home_q) begin
            done_d   = 1'b1;
            status_d = ST_OK;
            slot_d   = cur_q;
            fpay_d   = '0;
            state_d  = S_IDLE;
          end else begin
            cur_d   = home_q;
            n_d     = '0;
            state_d = S_TAIL_RD;
          end
        end else if (n_q == CntLast) begin
          done_d   = 1'b1;
          status_d = ST_FULL;
          slot_d   = '0;
          fpay_d   = '0;
          state_d  = S_IDLE;
        end else begin
          n_d     = n_q + 1'b1;
          cur_d   = cur_next;
          state_d = S_INS_RD;
        end
      end

      // walk the home chain to its tail
      S_TAIL_RD: state_d = S_TAIL_EV;

      S_TAIL_EV: begin
        if (!rlink[IDX_W] || rlink[IDX_W-1:0] == free_q) begin
          state_d = S_LINK_WR;
        end else begin
          cur_d = rlink[IDX_W-1:0];
          n_d   = n_q + 1'b1;
          if (n_q + 1'b1 == CntSize) begin
            state_d = S_LINK_WR;
          end else begin
            state_d = S_TAIL_RD;
          end
        end
      end

      S_LINK_WR: begin
        wr.we_link = 1'b1;
        wlink      = {1'b1, free_q};
        done_d     = 1'b1;
        status_d   = ST_OK;
        slot_d     = free_q;
        fpay_d     = '0;
        state_d    = S_IDLE;
      end

      // search along the chain
      S_SRCH_RD: state_d = S_SRCH_EV;

      S_SRCH_EV: begin
        if (rdata.used && rdata.key == key_q) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          slot_d   = cur_q;
          fpay_d   = rdata.payload;
          state_d  = S_IDLE;
        end else if (!rlink[IDX_W] || n_q + 1'b1 == CntSize) begin
          done_d   = 1'b1;
          status_d = ST_NOT_FOUND;
          slot_d   = '0;
          fpay_d   = '0;
          state_d  = S_IDLE;
        end else begin
          cur_d   = rlink[IDX_W-1:0];
          n_d     = n_q + 1'b1;
          state_d = S_SRCH_RD;
        end
      end

      // delete: clear the match, then relink its predecessor if there is one
      S_DEL_RD: state_d = S_DEL_EV;

      S_DEL_EV: begin
        if (!rdata.used) begin
          done_d   = 1'b1;
          status_d = ST_NOT_FOUND;
          slot_d   = '0;
          fpay_d   = '0;
          state_d  = S_IDLE;
        end else if (rdata.key == key_q) begin
          wr.we_data = 1'b1;
          wr.we_link = 1'b1;
          link_sv_d  = rlink;
          slot_d     = cur_q;
          status_d   = ST_OK;
          fpay_d     = '0;
          if (prev_v_q) begin
            state_d = S_DEL_RELINK;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (!rlink[IDX_W] || n_q + 1'b1 == CntSize) begin
          done_d   = 1'b1;
          status_d = ST_NOT_FOUND;
          slot_d   = '0;
          fpay_d   = '0;
          state_d  = S_IDLE;
        end else begin
          prev_d   = cur_q;
          prev_v_d = 1'b1;
          cur_d    = rlink[IDX_W-1:0];
          n_d      = n_q + 1'b1;
          state_d  = S_DEL_RD;
        end
      end

      S_DEL_RELINK: begin
        wr.we_link = 1'b1;
        waddr      = prev_q;
        wlink      = link_sv_q;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cur_q    <= '0;
      n_q      <= '0;
      prev_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      n_q      <= n_d;
      prev_v_q <= prev_v_d;
      done_q   <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    home_q    <= home_d;
    free_q    <= free_d;
    prev_q    <= prev_d;
    link_sv_q <= link_sv_d;
    op_q      <= op_d;
    key_q     <= key_d;
    pay_q     <= pay_d;
    status_q  <= status_d;
    slot_q    <= slot_d;
    fpay_q    <= fpay_d;
  end

  // result ports, slot masked to the output width
  assign slot_wide       = {{SLOT_OUT_W{1'b0}}, slot_q};
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign slot_index_o    = slot_wide[SLOT_OUT_W-1:0];
  assign found_payload_o = fpay_q;

endmodule

// ===== rtl/hct_mem.sv =====
module hct_mem import hct_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int unsigned IDX_W      = $clog2(TABLE_SIZE)
) (
  input  logic             clk_i,
  input  mem_wr_t          wr_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  slot_data_t       wdata_i,
  input  logic [IDX_W:0]   wlink_i,
  input  logic [IDX_W-1:0] raddr_i,
  output slot_data_t       rdata_o,
  output logic [IDX_W:0]   rlink_o
);

  // entry data and chain links, link msb is the valid flag
  slot_data_t     data_mem [TABLE_SIZE];
  logic [IDX_W:0] link_mem [TABLE_SIZE];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we_data) begin
      data_mem[waddr_i] <= wdata_i;
    end
    if (wr_i.we_link) begin
      link_mem[waddr_i] <= wlink_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= data_mem[raddr_i];
    rlink_o <= link_mem[raddr_i];
  end

endmodule

// ===== rtl/hct_mod.sv =====
module hct_mod import hct_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int unsigned IDX_W      = $clog2(TABLE_SIZE)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [IDX_W-1:0] rem_o
);

  // fold split of the key and fixed point scale of the reciprocal
  localparam int unsigned LO_W   = 17;
  localparam int unsigned X_W    = 28;
  localparam int unsigned PROD_W = 2 * X_W;
  localparam logic [X_W-1:0] FoldW   = X_W'((1 << LO_W) % TABLE_SIZE);
  localparam logic [X_W-1:0] Recip   = X_W'((1 << X_W) / TABLE_SIZE);
  localparam logic [X_W-1:0] Modulus = X_W'(TABLE_SIZE);

  // sequencer steps
  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_FOLD  = 3'd1;
  localparam logic [2:0] M_RECIP = 3'd2;
  localparam logic [2:0] M_BACK  = 3'd3;
  localparam logic [2:0] M_FIX   = 3'd4;

  logic [2:0]        step_q, step_d;
  logic              done_q, done_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [X_W-1:0]    acc_q, acc_d;
  logic [X_W-1:0]    quot_q, quot_d;
  logic [X_W-1:0]    mul_a;
  logic [X_W-1:0]    mul_b;
  logic [PROD_W-1:0] prod;

  // shared multiplier
  assign prod = {{X_W{1'b0}}, mul_a} * {{X_W{1'b0}}, mul_b};

  // fold the high key half, estimate the quotient by reciprocal,
  // multiply back, then one compare and subtract corrects the estimate
  always_comb begin
    step_d = step_q;
    done_d = 1'b0;
    key_d  = key_q;
    acc_d  = acc_q;
    quot_d = quot_q;
    mul_a  = '0;
    mul_b  = '0;
    unique case (step_q)
      M_IDLE: begin
        if (start_i) begin
          key_d  = key_i;
          step_d = M_FOLD;
        end
      end
      M_FOLD: begin
        mul_a  = X_W'(key_q[KEY_W-1:LO_W]);
        mul_b  = FoldW;
        acc_d  = prod[X_W-1:0] + X_W'(key_q[LO_W-1:0]);
        step_d = M_RECIP;
      end
      M_RECIP: begin
        mul_a  = acc_q;
        mul_b  = Recip;
        quot_d = prod[PROD_W-1:X_W];
        step_d = M_BACK;
      end
      M_BACK: begin
        mul_a  = quot_q;
        mul_b  = Modulus;
        acc_d  = acc_q - prod[X_W-1:0];
        step_d = M_FIX;
      end
      M_FIX: begin
        if (acc_q >= Modulus) begin
          acc_d = acc_q - Modulus;
        end
        done_d = 1'b1;
        step_d = M_IDLE;
      end
      default: step_d = M_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= M_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    acc_q  <= acc_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign rem_o  = acc_q[IDX_W-1:0];

endmodule

// ===== bench/table_check_pkg.sv =====
package table_check_pkg;
  import hct_pkg::*;

  localparam int unsigned TABLE_DEPTH = TABLE_SIZE_DEF;
  localparam int unsigned NO_LINK     = 32'hFFFF_FFFF;

  // one result transfer as seen on the ports
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [PAY_W-1:0]      payload;
  } table_reply_t;

  class table_scoreboard;
    // shadow copy of the slot store
    logic [KEY_W-1:0] slot_key[TABLE_DEPTH];
    logic [PAY_W-1:0] slot_payload[TABLE_DEPTH];
    int unsigned      slot_link[TABLE_DEPTH];
    bit               slot_used[TABLE_DEPTH];

    table_reply_t replies_due[$];
    int           error_count;

    function new();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_key[i]     = '0;
        slot_payload[i] = '0;
        slot_link[i]    = NO_LINK;
        slot_used[i]    = 1'b0;
      end
      error_count = 0;
    endfunction

    // update the shadow store for one command and return its reply
    function table_reply_t apply_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                         logic [PAY_W-1:0] pay);
      table_reply_t reply;
      int unsigned  home;
      int unsigned  free_slot;
      int unsigned  probe;
      int unsigned  tail;
      int unsigned  cur;
      int unsigned  prev;
      bit           got_free;
      reply = '0;
      home  = 32'(key % TABLE_DEPTH);
      if (key == '0) begin
        reply.status = ST_ZERO_KEY;
        return reply;
      end
      case (op)
        OP_INSERT: begin
          // home slot first, then linear probe for a free one
          free_slot = home;
          got_free  = 1'b1;
          if (slot_used[home]) begin
            got_free = 1'b0;
            for (int n = 1; n < TABLE_DEPTH; n++) begin
              probe = (home + n) % TABLE_DEPTH;
              if (!slot_used[probe]) begin
                free_slot = probe;
                got_free  = 1'b1;
                break;
              end
            end
          end
          if (!got_free) begin
            reply.status = ST_FULL;
            return reply;
          end
          slot_key[free_slot]     = key;
          slot_payload[free_slot] = pay;
          slot_link[free_slot]    = NO_LINK;
          slot_used[free_slot]    = 1'b1;
          // hang the new slot on the tail of the home chain
          if (free_slot != home) begin
            tail = home;
            for (int n = 0; n < TABLE_DEPTH; n++) begin
              if (slot_link[tail] >= TABLE_DEPTH || slot_link[tail] == free_slot) break;
              tail = slot_link[tail];
            end
            if (tail != free_slot) slot_link[tail] = free_slot;
          end
          reply.status = ST_OK;
          reply.slot   = SLOT_OUT_W'(free_slot);
        end
        OP_SEARCH: begin
          // walk the chain from home
          cur = home;
          reply.status = ST_NOT_FOUND;
          for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (slot_used[cur] && slot_key[cur] == key) begin
              reply.status  = ST_OK;
              reply.slot    = SLOT_OUT_W'(cur);
              reply.payload = slot_payload[cur];
              break;
            end
            if (slot_link[cur] >= TABLE_DEPTH) break;
            cur = slot_link[cur];
          end
        end
        OP_DELETE: begin
          // walk stops at the first unused slot
          cur  = home;
          prev = NO_LINK;
          reply.status = ST_NOT_FOUND;
          for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (!slot_used[cur]) break;
            if (slot_key[cur] == key) begin
              if (prev < TABLE_DEPTH) slot_link[prev] = slot_link[cur];
              slot_key[cur]     = '0;
              slot_payload[cur] = '0;
              slot_link[cur]    = NO_LINK;
              slot_used[cur]    = 1'b0;
              reply.status = ST_OK;
              reply.slot   = SLOT_OUT_W'(cur);
              break;
            end
            if (slot_link[cur] >= TABLE_DEPTH) break;
            prev = cur;
            cur  = slot_link[cur];
          end
        end
        default: begin
          reply.status = ST_NOT_FOUND;
        end
      endcase
      return reply;
    endfunction

    // true when deleting this key would drop a chain head that has successors
    function bit strands_successors(logic [KEY_W-1:0] key);
      int unsigned cur;
      cur = 32'(key % TABLE_DEPTH);
      for (int n = 0; n < TABLE_DEPTH; n++) begin
        if (!slot_used[cur]) return 1'b0;
        if (slot_key[cur] == key) return (n == 0) && (slot_link[cur] < TABLE_DEPTH);
        if (slot_link[cur] >= TABLE_DEPTH) return 1'b0;
        cur = slot_link[cur];
      end
      return 1'b0;
    endfunction

    // command transfer accepted
    function void note_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [PAY_W-1:0] pay);
      replies_due.push_back(apply_command(op, key, pay));
    endfunction

    // result transfer against the oldest pending reply
    function void check_result(table_reply_t got);
      table_reply_t exp;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d slot %0d payload %h",
                 $time, got.status, got.slot, got.payload);
        error_count++;
        return;
      end
      exp = replies_due.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp.status, got.status);
        error_count++;
      end
      if (got.slot !== exp.slot) begin
        $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                 $time, exp.slot, got.slot);
        error_count++;
      end
      if (got.payload !== exp.payload) begin
        $display("%0t: found_payload mismatch: expected %h, actual %h",
                 $time, exp.payload, got.payload);
        error_count++;
      end
    endfunction
  endclass

endpackage

// ===== bench/testbench.sv =====
module testbench;
  import hct_pkg::*;
  import table_check_pkg::*;

  localparam int ITEM_TARGET = 500;
  localparam int QUIET_FROM  = 430;
  localparam int TAIL_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;

  // op code outside the defined set
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [OP_W-1:0]       op_i;
  logic [KEY_W-1:0]      phone_key_i;
  logic [PAY_W-1:0]      name_payload_i;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [SLOT_OUT_W-1:0] slot_index_o;
  logic [PAY_W-1:0]      found_payload_o;

  table_scoreboard sb = new();
  int items_sent  = 0;
  int cycle_count = 0;

  chained_hash_table_linear_probe #(
    .TABLE_SIZE(TABLE_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .phone_key_i    (phone_key_i),
    .name_payload_i (name_payload_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .found_payload_o(found_payload_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result transfers
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result('{status: status_o, slot: slot_index_o, payload: found_payload_o});
    end
  end

  // hold one command until the block takes it
  task automatic send_command(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [PAY_W-1:0] pay);
    start          <= 1'b1;
    op_i           <= op;
    phone_key_i    <= key;
    name_payload_i <= pay;
    do @(posedge clk_i); while (busy);
    sb.note_command(op, key, pay);
    items_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // sender holds off until every pending reply is back
  task automatic wait_for_replies();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.replies_due.size() != 0);
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] pool[8];
    logic [3:0]       homes[3];
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    int               kind;
    int               span;
    int               roll;
    int               insert_pct;
    int               delete_pct;
    int               slot_pick;
    bit               idle_on;

    rst_ni         <= 1'b0;
    start          <= 1'b0;
    op_i           <= OP_INSERT;
    phone_key_i    <= '0;
    name_payload_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // key zero on every op, unknown op, empty table
    send_command(OP_INSERT, '0, '1);
    send_command(OP_SEARCH, '0, '0);
    send_command(OP_DELETE, '0, '0);
    send_command(OP_UNKNOWN, '0, '0);
    send_command(OP_UNKNOWN, 34'd7, '1);
    send_command(OP_SEARCH, 34'd5, '0);
    send_command(OP_DELETE, 34'd5, '0);
    // largest key and payload
    send_command(OP_INSERT, '1, '1);
    send_command(OP_SEARCH, '1, '0);
    // collisions on one home, duplicate key
    send_command(OP_INSERT, 34'd5, 64'h4A4F_484E_2020_2020);
    send_command(OP_INSERT, 34'd21, 64'h4D41_5259_2020_2020);
    send_command(OP_INSERT, 34'd37, 64'h5041_554C_2020_2020);
    send_command(OP_INSERT, 34'd21, 64'h414E_4E41_2020_2020);
    send_command(OP_SEARCH, 34'd21, '0);
    send_command(OP_SEARCH, 34'd37, '0);
    // unlink a middle entry, then the duplicate shows up
    send_command(OP_DELETE, 34'd21, '0);
    send_command(OP_SEARCH, 34'd21, '0);
    send_command(OP_INSERT, 34'd6, 64'h0123_4567_89AB_CDEF);
    // deleting the head strands the rest of the chain
    send_command(OP_DELETE, 34'd5, '0);
    send_command(OP_SEARCH, 34'd37, '0);
    // probe wraps past the last slot
    send_command(OP_INSERT, 34'd15, '0);
    send_command(OP_SEARCH, 34'd15, '0);
    send_command(OP_INSERT, 34'h2_0000_0000, 64'h8000_0000_0000_0001);
    wait_for_replies();

    // random episodes, each around a small pool of colliding keys
    while (items_sent < ITEM_TARGET) begin
      kind    = $urandom_range(0, 2);
      span    = $urandom_range(15, 50);
      idle_on = $urandom_range(0, 9) < 7;
      case (kind)
        0:       begin insert_pct = 45; delete_pct = 25; end
        1:       begin insert_pct = 20; delete_pct = 50; end
        default: begin insert_pct = 85; delete_pct = 5;  end
      endcase
      for (int h = 0; h < 3; h++) homes[h] = 4'($urandom_range(0, TABLE_DEPTH - 1));
      for (int p = 0; p < 8; p++) begin
        key = KEY_W'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0) key = KEY_W'($urandom_range(0, 3));
        key[3:0] = homes[$urandom_range(0, 2)];
        pool[p]  = key;
      end

      for (int i = 0; i < span && items_sent < ITEM_TARGET; i++) begin
        roll = $urandom_range(0, 99);
        pay  = {$urandom, $urandom};
        key  = pool[$urandom_range(0, 7)];
        // search and delete often target something actually stored
        slot_pick = $urandom_range(0, TABLE_DEPTH - 1);
        if ($urandom_range(0, 1) == 1 && sb.slot_used[slot_pick]) key = sb.slot_key[slot_pick];
        if (roll < 4) begin
          op  = OP_W'($urandom_range(0, 3));
          key = '0;
        end else if (roll < 7) begin
          op  = OP_UNKNOWN;
          key = KEY_W'({$urandom, $urandom});
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < insert_pct) begin
            op = OP_INSERT;
            if ($urandom_range(0, 9) == 0) key = KEY_W'({$urandom, $urandom});
          end else if (roll < insert_pct + delete_pct) begin
            op = OP_DELETE;
            // keep most chains intact so the table does not clog
            if (sb.strands_successors(key) && $urandom_range(0, 9) != 0) op = OP_SEARCH;
          end else begin
            op = OP_SEARCH;
          end
        end
        if (idle_on && items_sent < QUIET_FROM && $urandom_range(0, 4) == 0) begin
          pause_sender($urandom_range(1, 9));
        end
        send_command(op, key, pay);
      end
      if ($urandom_range(0, 2) == 0) wait_for_replies();
    end

    // drain and allow for stray results
    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0 && sb.replies_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
